// ===== src/dkfx_pkg.sv =====
package dkfx_pkg;

   // Field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned SLOT_W = 6;
   localparam int unsigned LEN_W = 7;
   localparam int unsigned OP_W = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 8;

   // Default ring depth
   localparam int unsigned KEY_DEPTH_DEFAULT = 64;

   // Item operation codes
   typedef enum logic [OP_W-1:0] {
      OP_DATA     = 2'd0,
      OP_RESTART  = 2'd1,
      OP_LOAD_ONE = 2'd2,
      OP_LOAD_TWO = 2'd3
   } op_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_ONE_LENGTH = 2'd0,
      CSR_KEY_TWO_LENGTH = 2'd1,
      CSR_FEEDBACK_SEED  = 2'd2
   } csr_index_type;

   // Per-ring control from the top level
   typedef struct packed {
      logic              advance;
      logic              restart;
      logic              load;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] data;
   } ring_ctl_type;

endpackage

// ===== src/dual_key_feedback_xor_cipher.sv =====
// Byte stream cipher: each data item returns byte_in XOR the current byte of
// key ring one, key ring two and a running feedback byte; the feedback byte
// then adds the low byte of the product of the two key bytes and both ring
// positions step forward, wrapping at their configured lengths. The same
// transform encrypts and decrypts. A restart item zeroes both positions and
// loads the feedback seed; load items write key bytes and return nothing.
// One item is accepted every cycle while the skid entry is empty, a rate set
// by the feedback loop, one 8x8 multiply-add per cycle, and by the key
// memories, whose read data is prefetched for the next ring position. A
// two-entry output buffer, the output register and a skid entry, keeps the
// request side moving while one result waits. Key memories need no clearing
// after reset; read only entries that have been written.
module dual_key_feedback_xor_cipher #(
   parameter int unsigned KEY_ONE_DEPTH = dkfx_pkg::KEY_DEPTH_DEFAULT,
   parameter int unsigned KEY_TWO_DEPTH = dkfx_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dkfx_pkg::OP_W-1:0]         req_op,
   input  logic [dkfx_pkg::BYTE_W-1:0]       req_byte_in,
   input  logic [dkfx_pkg::SLOT_W-1:0]       req_key_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dkfx_pkg::BYTE_W-1:0]       rsp_byte_out,
   input  logic                              csr_write_enable,
   input  logic [dkfx_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dkfx_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import dkfx_pkg::*;

   logic [LEN_W-1:0]  key_one_length_ff;
   logic [LEN_W-1:0]  key_two_length_ff;
   logic [BYTE_W-1:0] feedback_seed_ff;
   logic [BYTE_W-1:0] feedback_ff;
   logic [BYTE_W-1:0] feedback_in;

   logic              req_transfer;
   logic              rsp_transfer;
   op_type            op;
   logic              is_data;
   logic              is_restart;

   ring_ctl_type      ring_one_ctl;
   ring_ctl_type      ring_two_ctl;
   logic [BYTE_W-1:0] key_one_byte;
   logic [BYTE_W-1:0] key_two_byte;
   logic [2*BYTE_W-1:0] key_product;
   logic [BYTE_W-1:0] result;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic [BYTE_W-1:0] out_byte_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   logic [BYTE_W-1:0] skid_byte_ff;
   logic [BYTE_W-1:0] skid_byte_in;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_length_ff <= LEN_W'(1);
         key_two_length_ff <= LEN_W'(1);
         feedback_seed_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_ONE_LENGTH: key_one_length_ff <= LEN_W'(csr_write_data);
            CSR_KEY_TWO_LENGTH: key_two_length_ff <= LEN_W'(csr_write_data);
            CSR_FEEDBACK_SEED:  feedback_seed_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Request handshake and decode
   assign req_ready    = !skid_valid_ff;
   assign req_transfer = req_valid && req_ready;
   assign rsp_transfer = out_valid_ff && rsp_ready;
   assign op           = op_type'(req_op);
   assign is_data      = req_transfer && (op == OP_DATA);
   assign is_restart   = req_transfer && (op == OP_RESTART);

   // Ring controls
   always_comb begin
      ring_one_ctl.advance = is_data;
      ring_one_ctl.restart = is_restart;
      ring_one_ctl.load    = req_transfer && (op == OP_LOAD_ONE);
      ring_one_ctl.slot    = req_key_slot;
      ring_one_ctl.data    = req_byte_in;
      ring_two_ctl.advance = is_data;
      ring_two_ctl.restart = is_restart;
      ring_two_ctl.load    = req_transfer && (op == OP_LOAD_TWO);
      ring_two_ctl.slot    = req_key_slot;
      ring_two_ctl.data    = req_byte_in;
   end

   dkfx_key_ring #(
      .DEPTH (KEY_ONE_DEPTH)
   ) u_ring_one (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ring_one_ctl),
      .ring_length (key_one_length_ff),
      .key_byte    (key_one_byte)
   );

   dkfx_key_ring #(
      .DEPTH (KEY_TWO_DEPTH)
   ) u_ring_two (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ring_two_ctl),
      .ring_length (key_two_length_ff),
      .key_byte    (key_two_byte)
   );

   // Transform and feedback update
   assign result      = req_byte_in ^ key_one_byte ^ key_two_byte ^ feedback_ff;
   assign key_product = key_one_byte * key_two_byte;

   always_comb begin
      feedback_in = feedback_ff;
      priority if (is_restart) begin
         feedback_in = feedback_seed_ff;
      end else if (is_data) begin
         feedback_in = feedback_ff + key_product[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feedback_ff <= '0;
      end else begin
         feedback_ff <= feedback_in;
      end
   end

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      if (skid_valid_ff) begin
         if (rsp_transfer) begin
            out_byte_in   = skid_byte_ff;
            skid_valid_in = 1'b0;
         end
      end else if (is_data) begin
         if (!out_valid_ff || rsp_transfer) begin
            out_valid_in = 1'b1;
            out_byte_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_byte_in  = result;
         end
      end else if (rsp_transfer) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      skid_byte_ff <= skid_byte_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_byte_out = out_byte_ff;

endmodule

// ===== src/dkfx_key_ring.sv =====
module dkfx_key_ring #(
   parameter int unsigned DEPTH = dkfx_pkg::KEY_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dkfx_pkg::ring_ctl_type        ctl,
   input  logic [dkfx_pkg::LEN_W-1:0]    ring_length,
   output logic [dkfx_pkg::BYTE_W-1:0]   key_byte
);
   import dkfx_pkg::*;

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = 9;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [IW-1:0] POS_MASK = IW'((2 ** SLOT_W) - 1);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [IW-1:0]     pos_ff;
   logic [IW-1:0]     pos_in;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     wr_addr;
   logic              wr_en;
   logic [CW-1:0]     len_ext;
   logic [CW-1:0]     eff_len;
   logic [CW-1:0]     pos_inc;
   logic [BYTE_W-1:0] key_ff;

   // Clamp the length to 1..DEPTH
   always_comb begin
      len_ext = CW'(ring_length);
      if (len_ext == '0) begin
         eff_len = CW'(1);
      end else if (len_ext > DEPTH_C) begin
         eff_len = DEPTH_C;
      end else begin
         eff_len = len_ext;
      end
   end

   // Next ring position: restart to zero, advance with wrap
   assign pos_inc = CW'(pos_ff) + CW'(1);

   always_comb begin
      pos_in = pos_ff;
      priority if (ctl.restart) begin
         pos_in = '0;
      end else if (ctl.advance) begin
         pos_in = (pos_inc >= eff_len) ? '0 : (IW'(pos_inc) & POS_MASK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Key byte writes; slots beyond the depth drop
   assign wr_en   = ctl.load && (CW'(ctl.slot) < DEPTH_C);
   assign wr_addr = IW'(ctl.slot);
   assign rd_addr = reset ? '0 : pos_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= ctl.data;
      end
   end

   // Prefetch the byte at the next position; forward a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         key_ff <= ctl.data;
      end else begin
         key_ff <= mem[rd_addr];
      end
   end

   assign key_byte = key_ff;

endmodule
